FILE: rtl/core/padded_receptive_field_indexer_top_defines.svh
// Assertion macros for the receptive field indexer.
// Included by the top level; no other dependencies.
`ifndef PADDED_RECEPTIVE_FIELD_INDEXER_TOP_DEFINES_SVH
`define PADDED_RECEPTIVE_FIELD_INDEXER_TOP_DEFINES_SVH

`ifndef SYNTH
`define PRFI_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prfi: implication check failed");
`define PRFI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prfi: next-cycle check failed");
`else
`define PRFI_ASSERT_IMPLY(label, ante, cons)
`define PRFI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/prfi_pkg.sv
// Shared types and constants for the receptive field indexer.
// No dependencies.
package prfi_pkg;

  localparam int MAX_DIM = 1024;
  localparam int COORD_W = 14;  // padded coordinate: 1023*15 + 7
  localparam int DIM_W   = 11;
  localparam int IDX_W   = 24;
  localparam int PROD_W  = 21;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_PAD_AMOUNT   = 3'd2,
    REG_PAD_MODE     = 3'd3,
    REG_KERNEL_SIZE  = 3'd4,
    REG_STRIDE       = 3'd5,
    REG_PAD_INDEX    = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [3:0]       pad_amount;
    logic             pad_mode;
    logic [3:0]       kernel_size;
    logic [3:0]       stride;
    logic [IDX_W-1:0] pad_index;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] prow;
    logic [COORD_W-1:0] pcol;
    logic               last;
  } tap_t;

endpackage

FILE: rtl/core/prfi_seq.sv
// Tap sequencer: holds one output position and walks its kernel taps.
// Depends on prfi_pkg.
module prfi_seq
  import prfi_pkg::*;
#(
  parameter int MAX_KERNEL = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  out_row,
  input  logic [9:0]  out_col,
  output logic        tap_valid,
  input  logic        tap_ready,
  output tap_t        tap,
  output logic        busy
);

  localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

  logic [KW-1:0]      r;
  logic [KW-1:0]      c;
  logic [COORD_W-1:0] row_base;
  logic [COORD_W-1:0] col_base;
  logic [3:0]         k;
  logic               last;
  logic               advance;
  logic               accept;

  assign k = (cfg.kernel_size > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : cfg.kernel_size;
  assign last = (4'(r) == k - 4'd1) && (4'(c) == k - 4'd1);

  assign tap_valid = busy;
  assign advance   = busy && tap_ready;
  // nothing is taken while reset is held
  assign in_ready  = !rst && (!busy || (advance && last));
  assign accept    = in_valid && in_ready;

  assign tap.prow = row_base + COORD_W'(r);
  assign tap.pcol = col_base + COORD_W'(c);
  assign tap.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      r    <= '0;
      c    <= '0;
    end else if (accept) begin
      // zero kernel: item is taken and yields nothing
      busy <= (k != 4'd0);
      r    <= '0;
      c    <= '0;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end else if (4'(c) == k - 4'd1) begin
        c <= '0;
        r <= r + KW'(1);
      end else begin
        c <= c + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_base <= COORD_W'(out_row) * COORD_W'(cfg.stride);
      col_base <= COORD_W'(out_col) * COORD_W'(cfg.stride);
    end
  end

endmodule

FILE: rtl/core/prfi_pipe.sv
// Index pipeline: padded coordinate -> bounds check -> row product -> index.
// Depends on prfi_pkg.
module prfi_pipe
  import prfi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             tap_valid,
  output logic             tap_ready,
  input  tap_t             tap,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] tap_index,
  output logic             is_pad,
  output logic             last_tap
);

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [3:0]       offset;

  // stage 1: padded coordinates
  logic               v1;
  tap_t               s1;
  // stage 2: image coordinates and bounds
  logic               v2;
  logic [9:0]         rr2;
  logic [9:0]         cc2;
  logic               inside2;
  logic               last2;
  // stage 3: row product
  logic               v3;
  logic [PROD_W-1:0]  prod3;
  logic [9:0]         cc3;
  logic               inside3;
  logic               last3;

  logic [COORD_W-1:0] rr;
  logic [COORD_W-1:0] cc;
  logic               in_image;
  logic               en1, en2, en3, en4;

  assign w = (cfg.image_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
  assign h = (cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_height;
  assign offset = (cfg.pad_amount != 4'd0 && !cfg.pad_mode) ? cfg.pad_amount : 4'd0;

  assign en4 = !out_valid || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign tap_ready = en1;

  assign rr = s1.prow - COORD_W'(offset);
  assign cc = s1.pcol - COORD_W'(offset);
  assign in_image = (s1.prow >= COORD_W'(offset)) && (s1.pcol >= COORD_W'(offset)) &&
                    (rr < COORD_W'(h)) && (cc < COORD_W'(w));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= tap_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= tap;
    end
    if (en2) begin
      // in_image implies both image coordinates are below 1024
      rr2     <= rr[9:0];
      cc2     <= cc[9:0];
      inside2 <= in_image;
      last2   <= s1.last;
    end
    if (en3) begin
      prod3   <= PROD_W'(rr2) * PROD_W'(w);
      cc3     <= cc2;
      inside3 <= inside2;
      last3   <= last2;
    end
    if (en4) begin
      tap_index <= inside3 ? IDX_W'(prod3 + PROD_W'(cc3) + PROD_W'(1)) : cfg.pad_index;
      is_pad    <= !inside3;
      last_tap  <= last3;
    end
  end

endmodule

FILE: rtl/core/padded_receptive_field_indexer_top.sv
// Top level of the receptive field indexer: config registers, sequencer, pipeline.
// Depends on prfi_pkg, prfi_seq, prfi_pipe and the assertion macro header.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid / in_ready    | out_row, out_col
//   out     | output    | out_valid / out_ready  | tap_index, is_pad, last_tap
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One tap leaves per cycle when not stalled; an item yields k*k taps (k = kernel_size,
// capped at MAX_KERNEL), set by the tap sequencer; a zero kernel item yields none.
// A first tap crosses the sequencer and coordinate, bounds, product and index stages.
// The next item is taken in the cycle its predecessor's last tap enters the pipe.
// Synchronous reset clears all valids, holds in_ready and cfg_ready low, loads defaults.
// A full stage stalls only while the next one does; nothing is dropped or repeated.
`include "padded_receptive_field_indexer_top_defines.svh"

module padded_receptive_field_indexer_top
  import prfi_pkg::*;
#(
  parameter int MAX_KERNEL = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [9:0]       out_row,
  input  logic [9:0]       out_col,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] tap_index,
  output logic             is_pad,
  output logic             last_tap,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [IDX_W-1:0] cfg_data
);

  cfg_t cfg;
  tap_t tap;
  logic tap_valid;
  logic tap_ready;
  logic seq_busy;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= DIM_W'(28);
      cfg.image_height <= DIM_W'(28);
      cfg.pad_amount   <= 4'd0;
      cfg.pad_mode     <= 1'b0;
      cfg.kernel_size  <= 4'd3;
      cfg.stride       <= 4'd1;
      cfg.pad_index    <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[DIM_W-1:0];
        REG_PAD_AMOUNT:   cfg.pad_amount   <= cfg_data[3:0];
        REG_PAD_MODE:     cfg.pad_mode     <= cfg_data[0];
        REG_KERNEL_SIZE:  cfg.kernel_size  <= cfg_data[3:0];
        REG_STRIDE:       cfg.stride       <= cfg_data[3:0];
        REG_PAD_INDEX:    cfg.pad_index    <= cfg_data;
        default: ;
      endcase
    end
  end

  prfi_seq #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .tap       (tap),
    .busy      (seq_busy)
  );

  prfi_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .tap       (tap),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tap_index (tap_index),
    .is_pad    (is_pad),
    .last_tap  (last_tap)
  );

  // a busy sequencer takes a new item only as its last tap moves on
  `PRFI_ASSERT_IMPLY(a_seq_handoff, in_valid && in_ready && seq_busy, tap_ready && tap.last)
  // image taps are one-based, never zero
  `PRFI_ASSERT_IMPLY(a_index_nonzero, out_valid && !is_pad, tap_index != '0)
  // a stalled tap keeps its place in the kernel walk
  `PRFI_ASSERT_NEXT(a_tap_hold, tap_valid && !tap_ready && !rst,
                    tap_valid && $stable(tap.prow) && $stable(tap.pcol))

endmodule

FILE: test/padded_receptive_field_indexer_top_tb.sv
// Self-checking testbench for the receptive field indexer top level.
// Depends on prfi_pkg and padded_receptive_field_indexer_top; predicts every tap.
`timescale 1ns / 1ps

module padded_receptive_field_indexer_top_tb;
  import prfi_pkg::*;

  localparam int KERNEL_CAP = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int PRINT_CAP = 100;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             pad;
    logic             last;
  } tap_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [9:0]       out_row = '0;
  logic [9:0]       out_col = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [IDX_W-1:0] tap_index;
  logic             is_pad;
  logic             last_tap;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [IDX_W-1:0] cfg_data = '0;

  cfg_t        shadow_cfg;
  tap_result_t pending_taps[$];
  tap_result_t oldest_tap;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          steady = 1'b0;

  padded_receptive_field_indexer_top #(.MAX_KERNEL(KERNEL_CAP)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tap_index (tap_index),
    .is_pad    (is_pad),
    .last_tap  (last_tap),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_CAP) begin
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    end
    error_count++;
  endtask

  // Mostly short gaps, now and then a long one; none while steady.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [IDX_W-1:0] value);
    case (idx)
      REG_IMAGE_WIDTH:  shadow_cfg.image_width  = value[DIM_W-1:0];
      REG_IMAGE_HEIGHT: shadow_cfg.image_height = value[DIM_W-1:0];
      REG_PAD_AMOUNT:   shadow_cfg.pad_amount   = value[3:0];
      REG_PAD_MODE:     shadow_cfg.pad_mode     = value[0];
      REG_KERNEL_SIZE:  shadow_cfg.kernel_size  = value[3:0];
      REG_STRIDE:       shadow_cfg.stride       = value[3:0];
      REG_PAD_INDEX:    shadow_cfg.pad_index    = value;
      default: ;
    endcase
  endfunction

  // Expected taps of one output position, row-major over the kernel.
  function automatic void predict_taps(input logic [9:0] row, input logic [9:0] col);
    int unsigned k, w, h, offset, total, n, r, c, prow, pcol;
    bit in_image;
    tap_result_t tap;
    k = (shadow_cfg.kernel_size > KERNEL_CAP) ? KERNEL_CAP : shadow_cfg.kernel_size;
    w = (shadow_cfg.image_width > MAX_DIM) ? MAX_DIM : shadow_cfg.image_width;
    h = (shadow_cfg.image_height > MAX_DIM) ? MAX_DIM : shadow_cfg.image_height;
    offset = (shadow_cfg.pad_amount != 0 && !shadow_cfg.pad_mode) ?
             shadow_cfg.pad_amount : 0;
    total = k * k;
    n = 0;
    for (r = 0; r < k; r++) begin
      for (c = 0; c < k; c++) begin
        prow = row * shadow_cfg.stride + r;
        pcol = col * shadow_cfg.stride + c;
        in_image = prow >= offset && pcol >= offset &&
                   (prow - offset) < h && (pcol - offset) < w;
        tap.index = in_image ? IDX_W'((prow - offset) * w + (pcol - offset) + 1) :
                    shadow_cfg.pad_index;
        tap.pad = !in_image;
        tap.last = (n + 1 == total);
        pending_taps = {pending_taps, tap};
        n++;
      end
    end
  endfunction

  // Biased toward positions whose fields overlap the image.
  function automatic logic [9:0] pick_coord(input int unsigned side);
    int unsigned step, reach;
    step = (shadow_cfg.stride == 0) ? 1 : shadow_cfg.stride;
    if (side > MAX_DIM) side = MAX_DIM;
    reach = (side + 2 * shadow_cfg.pad_amount) / step + 1;
    if (reach > 1023) reach = 1023;
    if ($urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, reach));
  endfunction

  task automatic send_position(input logic [9:0] row, input logic [9:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    out_row <= row;
    out_col <= col;
    do @(posedge clk); while (!in_ready);
    predict_taps(row, col);
  endtask

  task automatic send_random_positions(input int count);
    repeat (count) begin
      send_position(pick_coord(shadow_cfg.image_height),
                    pick_coord(shadow_cfg.image_width));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk);
    // a zero kernel item may still be in flight with nothing expected
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [IDX_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
  endtask

  task automatic program_regs(input cfg_t next);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, IDX_W'(next.image_width));
    write_reg(REG_IMAGE_HEIGHT, IDX_W'(next.image_height));
    write_reg(REG_PAD_AMOUNT, IDX_W'(next.pad_amount));
    write_reg(REG_PAD_MODE, IDX_W'(next.pad_mode));
    write_reg(REG_KERNEL_SIZE, IDX_W'(next.kernel_size));
    write_reg(REG_STRIDE, IDX_W'(next.stride));
    write_reg(REG_PAD_INDEX, next.pad_index);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t make_cfg(input int unsigned w, input int unsigned h,
                                    input int unsigned pad, input bit mode,
                                    input int unsigned k, input int unsigned s,
                                    input int unsigned pidx);
    cfg_t next;
    next.image_width = DIM_W'(w);
    next.image_height = DIM_W'(h);
    next.pad_amount = 4'(pad);
    next.pad_mode = mode;
    next.kernel_size = 4'(k);
    next.stride = 4'(s);
    next.pad_index = IDX_W'(pidx);
    return next;
  endfunction

  task automatic test_reset_defaults();
    send_position(10'd0, 10'd0);
    send_position(10'd27, 10'd26);
    send_position(10'd1023, 10'd1023);
    send_position(10'd0, 10'd1023);
    send_random_positions(20);
  endtask

  task automatic test_unused_register();
    wait_idle();
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    send_position(10'd3, 10'd4);
    send_position(10'd26, 10'd0);
  endtask

  task automatic test_both_side_padding();
    program_regs(make_cfg(10, 7, 2, 1'b0, 5, 2, 24'hABCDE));
    send_position(10'd0, 10'd0);
    send_position(10'd4, 10'd5);
    send_position(10'd2, 10'd3);
    send_random_positions(15);
  endtask

  task automatic test_far_end_padding();
    program_regs(make_cfg(13, 9, 3, 1'b1, 4, 3, 24'h5A5A5A));
    send_position(10'd0, 10'd0);
    send_position(10'd3, 10'd4);
    send_random_positions(15);
  endtask

  task automatic test_extreme_sizes();
    // oversized sides clamp, largest pad, kernel and stride
    program_regs(make_cfg(2047, 1025, 15, 1'b0, 8, 15, 24'hFFFFFF));
    send_position(10'd0, 10'd0);
    send_position(10'd1023, 10'd1023);
    send_position(10'd68, 10'd1);
    program_regs(make_cfg(1, 1, 0, 1'b0, 1, 1, 24'h000001));
    send_position(10'd0, 10'd0);
    send_position(10'd0, 10'd1);
    send_position(10'd1023, 10'd0);
  endtask

  task automatic test_zero_kernel();
    program_regs(make_cfg(28, 28, 1, 1'b0, 0, 1, 24'h123456));
    send_position(10'd0, 10'd0);
    send_position(10'd5, 10'd5);
    send_random_positions(5);
    program_regs(make_cfg(28, 28, 1, 1'b0, 3, 1, 24'h123456));
    send_position(10'd1, 10'd2);
  endtask

  task automatic test_zero_stride();
    program_regs(make_cfg(5, 5, 1, 1'b0, 3, 0, 24'h00F00F));
    send_position(10'd1023, 10'd1023);
    send_position(10'd7, 10'd2);
  endtask

  task automatic test_zero_image();
    program_regs(make_cfg(0, 6, 0, 1'b0, 2, 1, 24'h0C0FFE));
    send_position(10'd0, 10'd0);
    program_regs(make_cfg(6, 0, 2, 1'b1, 2, 1, 24'h0BEEF0));
    send_position(10'd1, 10'd1);
  endtask

  task automatic test_oversized_kernel();
    program_regs(make_cfg(12, 12, 0, 1'b0, 15, 1, 24'h777777));
    send_position(10'd0, 10'd0);
    send_position(10'd5, 10'd5);
  endtask

  task automatic test_random_configs();
    cfg_t next;
    for (int round = 0; round < 12; round++) begin
      next.image_width = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2047)) :
                         DIM_W'($urandom_range(1, 40));
      next.image_height = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2047)) :
                          DIM_W'($urandom_range(1, 40));
      next.pad_amount = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
                        4'($urandom_range(0, 3));
      next.pad_mode = 1'($urandom_range(0, 1));
      next.kernel_size = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
                         4'($urandom_range(1, 5));
      next.stride = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
                    4'($urandom_range(1, 3));
      next.pad_index = IDX_W'($urandom());
      program_regs(next);
      steady = (round % 3 == 2);
      send_random_positions(28);
    end
    steady = 1'b0;
  endtask

  // Receiver side back-pressure.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_taps.size() == 0) begin
        report_mismatch("tap with no item pending", 32'(tap_index), 32'd0);
      end else begin
        oldest_tap = pending_taps.pop_front();
        if (tap_index !== oldest_tap.index)
          report_mismatch("tap_index", 32'(tap_index), 32'(oldest_tap.index));
        if (is_pad !== oldest_tap.pad)
          report_mismatch("is_pad", 32'(is_pad), 32'(oldest_tap.pad));
        if (last_tap !== oldest_tap.last)
          report_mismatch("last_tap", 32'(last_tap), 32'(oldest_tap.last));
      end
    end
  end

  // Watchdog: cycles with no handshake on any channel.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("padded_receptive_field_indexer_top_tb: errors");
    $finish;
  end

  initial begin
    shadow_cfg = make_cfg(28, 28, 0, 1'b0, 3, 1, 0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_unused_register();
    test_both_side_padding();
    test_far_end_padding();
    test_extreme_sizes();
    test_zero_kernel();
    test_zero_stride();
    test_zero_image();
    test_oversized_kernel();
    test_random_configs();
    wait_idle();
    if (error_count == 0) begin
      $display("padded_receptive_field_indexer_top_tb: clean");
    end else begin
      $display("padded_receptive_field_indexer_top_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/prfi_pkg.sv
rtl/core/prfi_seq.sv
rtl/core/prfi_pipe.sv
rtl/core/padded_receptive_field_indexer_top.sv
test/padded_receptive_field_indexer_top_tb.sv
